// ===== rtl/rds_group_sequencer_defines.svh =====
// assertion macros shared by the rds group sequencer checkers
`ifndef RDS_GROUP_SEQUENCER_DEFINES_SVH
`define RDS_GROUP_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define RDSGS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rds group sequencer check failed");

// next-cycle implication, held off while reset is asserted
`define RDSGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rds group sequencer check failed");

`endif

// ===== rtl/rdsgs_pkg.sv =====
// types and constants of the rds group sequencer
`default_nettype none

package rdsgs_pkg;

    localparam int TEXT_BYTES  = 64;
    localparam int TEXT_LANES  = 4;
    localparam int TEXT_ROWS   = TEXT_BYTES / TEXT_LANES;
    localparam int GROUP_SLOTS = 20;
    localparam int PS_SLOTS    = 4;

    localparam logic [15:0] PS_FILLER_WORD = 16'hE0CD;
    localparam logic [2:0]  REG_BLOCK_A    = 3'h3;
    localparam logic [2:0]  REG_BLOCK_BCD  = 3'h5;
    localparam logic [7:0]  CHAR_CR        = 8'h0D;
    localparam logic [7:0]  CHAR_SPACE     = 8'h20;
    localparam logic [15:0] MS_BIT         = 16'h0008;
    localparam logic [15:0] GROUP2A_BITS   = 16'h2000;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // block positions within a group
    localparam logic [1:0] POS_A = 2'd0;
    localparam logic [1:0] POS_B = 2'd1;
    localparam logic [1:0] POS_C = 2'd2;
    localparam logic [1:0] POS_D = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_PI_CODE        = 3'd0;
    localparam logic [2:0] CFG_PROGRAM_TYPE   = 3'd1;
    localparam logic [2:0] CFG_PS_NAME        = 3'd2;
    localparam logic [2:0] CFG_PS_THIRD_BLOCK = 3'd3;
    localparam logic [2:0] CFG_TEXT_AB_FLAG   = 3'd4;
    localparam logic [2:0] CFG_TEXT_LENGTH    = 3'd5;

    // configuration reset values
    localparam logic [15:0] PI_CODE_RESET      = 16'd28672;
    localparam logic [4:0]  PROGRAM_TYPE_RESET = 5'd3;
    localparam logic [63:0] PS_NAME_RESET      = 64'h2020202020202020;
    localparam logic [6:0]  TEXT_LENGTH_RESET  = 7'd1;

    typedef struct packed {
        logic       kind;
        logic [5:0] text_index;
        logic [7:0] text_char;
    } item_t;

    typedef struct packed {
        logic [2:0]  register_address;
        logic [15:0] block_word;
        logic [1:0]  block_position;
        logic [4:0]  next_group;
    } block_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } cfg_write_t;

endpackage

`default_nettype wire

// ===== rtl/rdsgs_if.sv =====
// valid/ready channel interfaces of the rds group sequencer
`default_nettype none

interface rdsgs_item_if;
    logic                 valid;
    logic                 ready;
    rdsgs_pkg::item_t     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rdsgs_block_if;
    logic                 valid;
    logic                 ready;
    rdsgs_pkg::block_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rdsgs_cfg_if;
    logic                   valid;
    logic                   ready;
    rdsgs_pkg::cfg_write_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rds_group_sequencer.sv =====
// rds group sequencer: service name and radiotext block generator
// Channels: items (sink) carries tick and text-write beats, blocks (source)
// carries one rds block per tick, cfg (sink) writes the six configuration
// registers and is always ready.
// A tick beat yields one block, a text-write beat yields none and updates
// the 64-byte radiotext store (16 rows of four bytes, one byte lane per write).
// An accepted beat is held in the input register and processed from there;
// a tick's block is then registered in the output register, where it can
// be taken. One beat per cycle is taken while blocks.ready stays high.
// The four text characters of a radiotext group are read as one memory row
// when block A is processed and kept until blocks C and D go out.
// Reset returns the registers to their defaults, restarts at group slot 0,
// and marks every text byte unwritten, so it reads as carriage return (byte 0)
// or space; no clearing pass is needed.
// When blocks.ready is low the pending block holds; write beats still pass
// until a tick reaches the input register, which then waits there and keeps
// items.ready low until the pending block is taken.
`default_nettype none

module rds_group_sequencer
(
    input  wire            clk,
    input  wire            rst_n,
    rdsgs_item_if.sink     items,
    rdsgs_block_if.source  blocks,
    rdsgs_cfg_if.sink      cfg
);

    // configuration registers
    logic [15:0] pi_code_reg;
    logic [4:0]  program_type_reg;
    logic [63:0] ps_name_reg;
    logic [15:0] ps_third_block_reg;
    logic        text_ab_flag_reg;
    logic [6:0]  text_length_reg;

    // input and output stages
    rdsgs_pkg::item_t  in_item_reg;
    logic              in_valid_reg;
    rdsgs_pkg::block_t out_reg;
    rdsgs_pkg::block_t out_next;
    logic              out_valid_reg;

    // sequencer state
    logic [4:0]  group_slot_reg;
    logic [4:0]  group_slot_next;
    logic [1:0]  block_slot_reg;
    logic        sending_text_reg;
    logic        sending_text_next;
    logic [3:0]  segment_reg;
    logic [3:0]  segment_next;
    logic [15:0] ps_word_d_reg;
    logic [15:0] ps_word_d_next;
    logic [3:0]  text_row_reg;
    logic [3:0][7:0] text_raw_reg;
    logic [3:0]  text_valid_reg;

    // radiotext store and per-byte written marks
    logic [3:0][7:0] text_mem [rdsgs_pkg::TEXT_ROWS];
    logic [3:0]      byte_valid_reg [rdsgs_pkg::TEXT_ROWS];

    logic        in_advance;
    logic        proc_tick;
    logic        proc_write;
    logic        group_start;
    logic [4:0]  rel_slot;
    logic [3:0]  text_row;
    logic [6:0]  text_off;
    logic        text_slot;
    logic        take_text;
    logic [4:0]  slot_now;
    logic [7:0]  text_char [rdsgs_pkg::TEXT_LANES];
    logic [15:0] word;

    assign in_advance = in_valid_reg
                      && (in_item_reg.kind == rdsgs_pkg::KIND_WRITE
                          || !out_valid_reg || blocks.ready);
    assign proc_tick  = in_advance && (in_item_reg.kind == rdsgs_pkg::KIND_TICK);
    assign proc_write = in_advance && (in_item_reg.kind == rdsgs_pkg::KIND_WRITE);

    assign items.ready  = !in_valid_reg || in_advance;
    assign cfg.ready    = 1'b1;
    assign blocks.valid = out_valid_reg;
    assign blocks.data  = out_reg;

    // group start decision, made when block A is processed
    always_comb
    begin
        group_start = (block_slot_reg == rdsgs_pkg::POS_A);
        rel_slot    = group_slot_reg - 5'(rdsgs_pkg::PS_SLOTS);
        text_row    = rel_slot[3:0];
        text_off    = {1'b0, text_row, 2'b00};
        text_slot   = (group_slot_reg >= 5'(rdsgs_pkg::PS_SLOTS));
        take_text   = text_slot && (text_off < text_length_reg);
        slot_now    = (group_start && text_slot && !take_text) ? 5'd0 : group_slot_reg;

        if (group_start)
        begin
            sending_text_next = take_text;
            segment_next      = take_text ? text_row : {2'b00, slot_now[1:0]};
        end
        else
        begin
            sending_text_next = sending_text_reg;
            segment_next      = segment_reg;
        end

        unique case (segment_next[1:0])
            2'd0:    ps_word_d_next = ps_name_reg[63:48];
            2'd1:    ps_word_d_next = ps_name_reg[47:32];
            2'd2:    ps_word_d_next = ps_name_reg[31:16];
            default: ps_word_d_next = ps_name_reg[15:0];
        endcase

        if (block_slot_reg == rdsgs_pkg::POS_D)
        begin
            group_slot_next = (slot_now == 5'(rdsgs_pkg::GROUP_SLOTS - 1))
                            ? 5'd0 : slot_now + 5'd1;
        end
        else
        begin
            group_slot_next = slot_now;
        end
    end

    // unwritten bytes read as their reset character
    always_comb
    begin
        for (int l = 0; l < rdsgs_pkg::TEXT_LANES; l++)
        begin
            if (text_valid_reg[l])
                text_char[l] = text_raw_reg[l];
            else if (text_row_reg == 4'd0 && l == 0)
                text_char[l] = rdsgs_pkg::CHAR_CR;
            else
                text_char[l] = rdsgs_pkg::CHAR_SPACE;
        end
    end

    always_comb
    begin
        unique case (block_slot_reg)
            rdsgs_pkg::POS_A:
                word = pi_code_reg;
            rdsgs_pkg::POS_B:
                word = sending_text_next
                     ? (rdsgs_pkg::GROUP2A_BITS
                        | {6'b0, program_type_reg, text_ab_flag_reg, segment_next})
                     : ({6'b0, program_type_reg, 5'b0} | rdsgs_pkg::MS_BIT
                        | {12'b0, segment_next});
            rdsgs_pkg::POS_C:
                word = sending_text_next ? {text_char[0], text_char[1]}
                                         : ps_third_block_reg;
            default:
                word = sending_text_next ? {text_char[2], text_char[3]}
                                         : ps_word_d_reg;
        endcase

        out_next.register_address = (block_slot_reg == rdsgs_pkg::POS_A)
                                  ? rdsgs_pkg::REG_BLOCK_A : rdsgs_pkg::REG_BLOCK_BCD;
        out_next.block_word       = word;
        out_next.block_position   = block_slot_reg;
        out_next.next_group       = group_slot_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pi_code_reg        <= rdsgs_pkg::PI_CODE_RESET;
            program_type_reg   <= rdsgs_pkg::PROGRAM_TYPE_RESET;
            ps_name_reg        <= rdsgs_pkg::PS_NAME_RESET;
            ps_third_block_reg <= rdsgs_pkg::PS_FILLER_WORD;
            text_ab_flag_reg   <= 1'b0;
            text_length_reg    <= rdsgs_pkg::TEXT_LENGTH_RESET;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            group_slot_reg     <= '0;
            block_slot_reg     <= '0;
            sending_text_reg   <= 1'b0;
            segment_reg        <= '0;
            for (int r = 0; r < rdsgs_pkg::TEXT_ROWS; r++)
            begin
                byte_valid_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.data.index)
                    rdsgs_pkg::CFG_PI_CODE:        pi_code_reg <= cfg.data.data[15:0];
                    rdsgs_pkg::CFG_PROGRAM_TYPE:   program_type_reg <= cfg.data.data[4:0];
                    rdsgs_pkg::CFG_PS_NAME:        ps_name_reg <= cfg.data.data;
                    rdsgs_pkg::CFG_PS_THIRD_BLOCK: ps_third_block_reg <= cfg.data.data[15:0];
                    rdsgs_pkg::CFG_TEXT_AB_FLAG:   text_ab_flag_reg <= cfg.data.data[0];
                    rdsgs_pkg::CFG_TEXT_LENGTH:    text_length_reg <= cfg.data.data[6:0];
                    default: ;
                endcase
            end

            if (items.valid && items.ready)
                in_valid_reg <= 1'b1;
            else if (in_advance)
                in_valid_reg <= 1'b0;

            if (proc_tick)
                out_valid_reg <= 1'b1;
            else if (blocks.ready)
                out_valid_reg <= 1'b0;

            if (proc_tick)
            begin
                group_slot_reg   <= group_slot_next;
                block_slot_reg   <= block_slot_reg + 2'd1;
                sending_text_reg <= sending_text_next;
                segment_reg      <= segment_next;
            end

            if (proc_write)
            begin
                byte_valid_reg[in_item_reg.text_index[5:2]][in_item_reg.text_index[1:0]]
                    <= 1'b1;
            end
        end
    end

    // payload registers and the text store
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
            in_item_reg <= items.data;

        if (proc_tick)
            out_reg <= out_next;

        if (proc_tick && group_start)
        begin
            ps_word_d_reg  <= ps_word_d_next;
            text_row_reg   <= text_row;
            text_raw_reg   <= text_mem[text_row];
            text_valid_reg <= byte_valid_reg[text_row];
        end

        if (proc_write)
        begin
            text_mem[in_item_reg.text_index[5:2]][in_item_reg.text_index[1:0]]
                <= in_item_reg.text_char;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rdsgs_checker.sv =====
// port-level checks of the rds group sequencer and their bind
`default_nettype none
`include "rds_group_sequencer_defines.svh"

module rdsgs_checker
(
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire [2:0] register_address,
    input wire [1:0] block_position,
    input wire [4:0] next_group
);

    // a pending block is not withdrawn
    `RDSGS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // block A goes to the A register, all others to the B-D register
    `RDSGS_ASSERT_IMPL(a_addr_pos, clk, rst_n, out_valid, (block_position == rdsgs_pkg::POS_A) == (register_address == rdsgs_pkg::REG_BLOCK_A) && (register_address == rdsgs_pkg::REG_BLOCK_A || register_address == rdsgs_pkg::REG_BLOCK_BCD))

    // the next group slot stays in range
    `RDSGS_ASSERT_IMPL(a_slot_range, clk, rst_n, out_valid, next_group < 5'(rdsgs_pkg::GROUP_SLOTS))

endmodule

bind rds_group_sequencer rdsgs_checker u_rdsgs_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (blocks.valid),
    .out_ready        (blocks.ready),
    .register_address (blocks.data.register_address),
    .block_position   (blocks.data.block_position),
    .next_group       (blocks.data.next_group)
);

`default_nettype wire
